@@ design/bit_timed_uart_transceiver_top_defines.svh @@
// Assertion helpers used by the top-level RTL
`ifndef BIT_TIMED_UART_TRANSCEIVER_TOP_DEFINES_SVH
`define BIT_TIMED_UART_TRANSCEIVER_TOP_DEFINES_SVH

// same-cycle implication
`define BTUT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BTUT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/btut_pkg.sv @@
package btut_pkg;

   localparam int DATA_BITS_DEF = 8;
   localparam int BYTE_W        = 8;
   localparam int PERIOD_W      = 16;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd8;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd2;
   localparam logic [1:0]          STOP_RST   = 2'd1;
   localparam logic [1:0]          STOP_TWO   = 2'd2;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_PERIOD     = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_STOP       = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_START_HIGH = 4'h8;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;    // already clamped to at least two
      logic                two_stop;
      logic                start_high;
   } cfg_type;

endpackage

@@ design/btut_req_if.sv @@
interface btut_req_if;
   logic       valid;
   logic       ready;
   logic       rx_line;
   logic       send_request;
   logic [7:0] send_data;

   modport source (output valid, rx_line, send_request, send_data, input ready);
   modport sink   (input valid, rx_line, send_request, send_data, output ready);
endinterface

@@ design/btut_rsp_if.sv @@
interface btut_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_line;
   logic       tx_busy;
   logic       rx_valid;
   logic [7:0] rx_byte;

   modport source (output valid, tx_line, tx_busy, rx_valid, rx_byte, input ready);
   modport sink   (input valid, tx_line, tx_busy, rx_valid, rx_byte, output ready);
endinterface

@@ design/bit_timed_uart_transceiver_top.sv @@
// Bit-timed UART transceiver, one line tick per request transfer.
// req_chan carries one tick: the sampled receive level, a send request and
// the byte to send. rsp_chan returns one result per tick: transmit level,
// transmitter busy flag, and a received byte with its valid flag.
// Transmitter: start bit low, 8 data bits LSB first, one or two stop bits,
// each one bit period long; a request while busy is dropped.
// Receiver: waits for the start level, samples mid-bit, reports the byte one
// period after the last data bit, framing unchecked.
// Timing: the result of a tick is registered and is on rsp_chan in the cycle after its transfer.
// Throughput: one tick per cycle while rsp_chan takes the results; the tick
// logic is a single pass from the accepted fields and state registers into the result register.
// Stalls: the result register holds while rsp_chan.ready is low; req_chan
// keeps accepting as long as the result register is empty or being drained.
// Reset (synchronous, active high): both sides idle, result register empty,
// registers back to 8 ticks per bit, one stop bit, idle-high receive.
// CSR map (APB, pready tied high): 0x0 bit period, 0x4 stop bits,
// 0x8 receive polarity.
`include "bit_timed_uart_transceiver_top_defines.svh"

module bit_timed_uart_transceiver_top #(
   parameter int DATA_BITS = btut_pkg::DATA_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   btut_req_if.sink                          req_chan,
   btut_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [btut_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [btut_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [btut_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import btut_pkg::*;

   // configuration registers
   logic [PERIOD_W-1:0] period_ff;
   logic [1:0]          stop_ff;
   logic                start_high_ff;
   logic                csr_wr;
   cfg_type             cfg;

   // tick transfer and result register
   logic                step;
   logic                tx_line, tx_busy;
   logic                rx_valid;
   logic [BYTE_W-1:0]   rx_byte;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_tx_line_ff, rsp_tx_busy_ff, rsp_rx_valid_ff;
   logic [BYTE_W-1:0]   rsp_rx_byte_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= PERIOD_RST;
         stop_ff       <= STOP_RST;
         start_high_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr)
            ADDR_PERIOD:     period_ff     <= csr_pwdata[PERIOD_W-1:0];
            ADDR_STOP:       stop_ff       <= csr_pwdata[1:0];
            ADDR_START_HIGH: start_high_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_PERIOD:     csr_prdata = {{(CSR_DATA_W-PERIOD_W){1'b0}}, period_ff};
         ADDR_STOP:       csr_prdata = {{(CSR_DATA_W-2){1'b0}}, stop_ff};
         ADDR_START_HIGH: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, start_high_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // periods below two behave as two
   assign cfg.period     = (period_ff < PERIOD_MIN) ? PERIOD_MIN : period_ff;
   assign cfg.two_stop   = (stop_ff == STOP_TWO);
   assign cfg.start_high = start_high_ff;

   // take a tick whenever the result register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_chan.valid && req_chan.ready;

   btut_tx u_tx (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .cfg          (cfg),
      .send_request (req_chan.send_request),
      .send_data    (req_chan.send_data),
      .tx_line      (tx_line),
      .tx_busy      (tx_busy)
   );

   btut_rx #(
      .DATA_BITS (DATA_BITS)
   ) u_rx (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .cfg      (cfg),
      .rx_line  (req_chan.rx_line),
      .rx_valid (rx_valid),
      .rx_byte  (rx_byte)
   );

   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_tx_line_ff  <= tx_line;
         rsp_tx_busy_ff  <= tx_busy;
         rsp_rx_valid_ff <= rx_valid;
         rsp_rx_byte_ff  <= rx_byte;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.tx_line  = rsp_tx_line_ff;
   assign rsp_chan.tx_busy  = rsp_tx_busy_ff;
   assign rsp_chan.rx_valid = rsp_rx_valid_ff;
   assign rsp_chan.rx_byte  = rsp_rx_byte_ff;

   // every accepted tick leaves a result behind
   `BTUT_ASSERT_NXT(a_step_fills, clock, reset, step, rsp_valid_ff, "tick result lost")
   // idle transmitter drives the line high
   `BTUT_ASSERT_IMP(a_idle_high, clock, reset, rsp_valid_ff && !rsp_tx_busy_ff,
      rsp_tx_line_ff, "idle tx line not high")
   // no byte data without a completed byte
   `BTUT_ASSERT_IMP(a_byte_zero, clock, reset, rsp_valid_ff && !rsp_rx_valid_ff,
      rsp_rx_byte_ff == '0, "rx byte set without rx valid")
   // a pending result that is taken with no new tick empties the register
   `BTUT_ASSERT_NXT(a_drain, clock, reset, rsp_valid_ff && rsp_chan.ready && !step,
      !rsp_valid_ff, "result repeated")

endmodule

@@ design/btut_tx.sv @@
module btut_tx (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  btut_pkg::cfg_type             cfg,
   input  logic                          send_request,
   input  logic [btut_pkg::BYTE_W-1:0]   send_data,
   output logic                          tx_line,
   output logic                          tx_busy
);
   import btut_pkg::*;

   phase_type           phase_ff, phase_in, phase_cur;
   logic [PERIOD_W-1:0] cnt_ff, cnt_in, cnt_cur;
   logic                idx_stop_ff, idx_stop_in;
   logic [2:0]          idx_ff, idx_in, idx_cur;
   logic [BYTE_W-1:0]   shift_ff, shift_in, shift_cur;
   logic [PERIOD_W:0]   cnt_inc;
   logic                bit_done;

   // a request while idle makes this tick the first start tick
   always_comb begin
      phase_cur = phase_ff;
      cnt_cur   = cnt_ff;
      idx_cur   = idx_ff;
      shift_cur = shift_ff;
      if (phase_ff == PH_IDLE && send_request) begin
         phase_cur = PH_START;
         cnt_cur   = '0;
         idx_cur   = '0;
         shift_cur = send_data;
      end
   end

   assign cnt_inc  = {1'b0, cnt_cur} + 1'b1;
   assign bit_done = (cnt_inc >= {1'b0, cfg.period});

   // next state
   always_comb begin
      phase_in    = phase_cur;
      cnt_in      = cnt_cur;
      idx_in      = idx_cur;
      idx_stop_in = idx_stop_ff;
      shift_in    = shift_cur;
      if (phase_cur != PH_IDLE) begin
         cnt_in = bit_done ? '0 : cnt_inc[PERIOD_W-1:0];
      end
      if (phase_cur == PH_START) begin
         idx_stop_in = 1'b0;
      end
      if (bit_done) begin
         case (phase_cur)
            PH_START: begin
               phase_in = PH_DATA;
               idx_in   = '0;
            end
            PH_DATA: begin
               idx_in = idx_cur + 1'b1;
               if (idx_cur == 3'd7) begin
                  phase_in    = PH_STOP;
                  idx_stop_in = 1'b0;
               end
            end
            PH_STOP: begin
               if (cfg.two_stop && !idx_stop_ff) begin
                  idx_stop_in = 1'b1;
               end else begin
                  phase_in    = PH_IDLE;
                  idx_stop_in = 1'b0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // line outputs
   always_comb begin
      case (phase_cur)
         PH_START: begin
            tx_line = 1'b0;
            tx_busy = 1'b1;
         end
         PH_DATA: begin
            tx_line = shift_cur[idx_cur];
            tx_busy = 1'b1;
         end
         PH_STOP: begin
            tx_line = 1'b1;
            tx_busy = 1'b1;
         end
         default: begin
            tx_line = 1'b1;
            tx_busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cnt_ff      <= '0;
         idx_ff      <= '0;
         idx_stop_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
         idx_stop_ff <= idx_stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         shift_ff <= shift_in;
      end
   end

endmodule

@@ design/btut_rx.sv @@
module btut_rx #(
   parameter int DATA_BITS = btut_pkg::DATA_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  btut_pkg::cfg_type             cfg,
   input  logic                          rx_line,
   output logic                          rx_valid,
   output logic [btut_pkg::BYTE_W-1:0]   rx_byte
);
   import btut_pkg::*;

   localparam int IDX_W = $clog2(DATA_BITS + 1);

   phase_type           phase_ff, phase_in;
   logic [PERIOD_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]    idx_ff, idx_in, idx_inc;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic [PERIOD_W:0]   cnt_inc;
   logic                half_done;
   logic                bit_done;
   logic                start_seen;

   assign cnt_inc    = {1'b0, cnt_ff} + 1'b1;
   assign half_done  = (cnt_inc >= {2'b00, cfg.period[PERIOD_W-1:1]});
   assign bit_done   = (cnt_inc >= {1'b0, cfg.period});
   assign start_seen = (rx_line == cfg.start_high);
   assign idx_inc    = idx_ff + 1'b1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_inc[PERIOD_W-1:0];
      idx_in   = idx_ff;
      shift_in = shift_ff;
      case (phase_ff)
         PH_IDLE: begin
            cnt_in = '0;
            if (start_seen) begin
               phase_in = PH_START;
            end
         end
         PH_START: begin
            if (half_done) begin
               phase_in = PH_DATA;
               cnt_in   = '0;
               idx_in   = '0;
               shift_in = '0;
            end
         end
         PH_DATA: begin
            if (bit_done) begin
               cnt_in = '0;
               // data bits past the eighth are sampled but not kept
               if (int'(idx_ff) < BYTE_W) begin
                  shift_in[idx_ff[2:0]] = rx_line;
               end
               idx_in = idx_inc;
               if (idx_inc == IDX_W'(DATA_BITS)) begin
                  phase_in = PH_STOP;
               end
            end
         end
         PH_STOP: begin
            if (bit_done) begin
               phase_in = PH_IDLE;
               cnt_in   = '0;
               idx_in   = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // byte report
   always_comb begin
      rx_valid = 1'b0;
      rx_byte  = '0;
      case (phase_ff)
         PH_STOP: begin
            if (bit_done) begin
               rx_valid = 1'b1;
               rx_byte  = shift_ff;
            end
         end
         default: begin
            rx_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else if (step) begin
         shift_ff <= shift_in;
      end
   end

endmodule
